// ----- hdl/swmm_pkg.sv -----
package swmm_pkg;

    localparam int SAMPLE_WIDTH = 16;
    localparam int WINDOW_MAX   = 64;
    localparam int LEN_W        = 7;
    localparam int CNT_W        = $clog2(WINDOW_MAX + 1);
    localparam int IDX_W        = $clog2(WINDOW_MAX);
    localparam int PADDR_W      = 3;
    localparam int PDATA_W      = 32;

    localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(4);

    // register index decoded from paddr[2]
    localparam logic [0:0] REG_WINDOW_LENGTH = 1'b0;

    typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;

    typedef struct packed {
        sample_t sample;
        logic    restart;
    } in_item_t;

    typedef struct packed {
        sample_t window_min;
        sample_t window_max;
        logic    valid_res;
    } out_item_t;

    // running min/max traveling down the cell chain
    typedef struct packed {
        logic    active;
        sample_t lo;
        sample_t hi;
    } tok_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_PEND
    } state_t;

endpackage

// ----- hdl/swmm_cell.sv -----
module swmm_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              shift_en,
    input  swmm_pkg::sample_t samp_in,
    output swmm_pkg::sample_t samp,
    input  logic              inject,
    input  swmm_pkg::tok_t    tok_in,
    output swmm_pkg::tok_t    tok_out
);

    swmm_pkg::sample_t samp_reg;
    swmm_pkg::tok_t    tok_reg;
    swmm_pkg::tok_t    tok_next;

    // stored sample, shifts one place older per accepted item
    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            samp_reg <= samp_in;
        end
    end

    // inject starts a fresh min/max at this cell, else fold own sample in
    always_comb
    begin
        tok_next.active = inject | tok_in.active;
        if (inject)
        begin
            tok_next.lo = samp_reg;
            tok_next.hi = samp_reg;
        end
        else
        begin
            tok_next.lo = (tok_in.lo < samp_reg) ? tok_in.lo : samp_reg;
            tok_next.hi = (tok_in.hi > samp_reg) ? tok_in.hi : samp_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    assign samp    = samp_reg;
    assign tok_out = tok_reg;

endmodule

// ----- hdl/sliding_window_min_max.sv -----
// Channel   Direction  Handshake             Payload
// smp       in         smp_valid/smp_stall   swmm_pkg::in_item_t  (sample, restart)
// res       out        res_valid/res_stall   swmm_pkg::out_item_t (window_min, window_max,
//                                                                   valid_res)
// apb       cfg        psel/penable/pready   window_length at byte address 0
//
// One item at a time. An accepted sample shifts into a chain of 64 cells
// (cell 0 newest). A min/max token is started at cell count-1, where count is
// min(samples in series, window length), and walks one cell per cycle to cell 0.
// The next item is taken only after the token has walked the chain. Results wait
// in an output register and one pending register, so a stalled result side
// blocks new items only once both are full. Reset clears control state and sets
// window_length to 4; stored samples need no clearing since only samples of the
// current series are read.
module sliding_window_min_max (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // sample channel
    input  logic                                 smp_valid,
    output logic                                 smp_stall,
    input  swmm_pkg::in_item_t                   smp,
    // result channel
    output logic                                 res_valid,
    input  logic                                 res_stall,
    output swmm_pkg::out_item_t                  res,
    // config port
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [swmm_pkg::PADDR_W-1:0]         paddr,
    input  logic [swmm_pkg::PDATA_W-1:0]         pwdata,
    output logic [swmm_pkg::PDATA_W-1:0]         prdata,
    output logic                                 pready
);

    localparam int N = swmm_pkg::WINDOW_MAX;

    // ------------------------------------------------------------------
    // config register
    // ------------------------------------------------------------------
    logic [swmm_pkg::LEN_W-1:0] len_reg;
    logic                       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready
                    & (paddr[2:2] == swmm_pkg::REG_WINDOW_LENGTH);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= swmm_pkg::LEN_RESET;
        end
        else if (cfg_wr)
        begin
            len_reg <= pwdata[swmm_pkg::LEN_W-1:0];
        end
    end

    always_comb
    begin
        unique case (paddr[2:2])
            swmm_pkg::REG_WINDOW_LENGTH:
                prdata = swmm_pkg::PDATA_W'(len_reg);
            default:
                prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // series bookkeeping, done at accept
    // ------------------------------------------------------------------
    logic                       smp_acc;
    logic [swmm_pkg::CNT_W-1:0] fill_reg, fill_next;
    logic [swmm_pkg::CNT_W-1:0] len_eff;
    logic [swmm_pkg::CNT_W-1:0] count_new;
    logic [swmm_pkg::IDX_W-1:0] inj_idx_reg;
    logic                       vres_reg;
    logic                       start_reg;

    assign smp_acc = smp_valid & ~smp_stall;

    // zero length acts as 1, anything past the chain length saturates
    always_comb
    begin
        if (len_reg == '0)
        begin
            len_eff = swmm_pkg::CNT_W'(1);
        end
        else if (swmm_pkg::CNT_W'(len_reg) > swmm_pkg::CNT_W'(N))
        begin
            len_eff = swmm_pkg::CNT_W'(N);
        end
        else
        begin
            len_eff = swmm_pkg::CNT_W'(len_reg);
        end
    end

    always_comb
    begin
        if (smp.restart)
        begin
            fill_next = swmm_pkg::CNT_W'(1);
        end
        else if (fill_reg < swmm_pkg::CNT_W'(N))
        begin
            fill_next = fill_reg + swmm_pkg::CNT_W'(1);
        end
        else
        begin
            fill_next = fill_reg;
        end
        count_new = (fill_next < len_eff) ? fill_next : len_eff;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg  <= '0;
            start_reg <= 1'b0;
        end
        else
        begin
            start_reg <= smp_acc;
            if (smp_acc)
            begin
                fill_reg <= fill_next;
            end
        end
    end

    // count is 1..N, so count-1 always fits the cell index
    always_ff @(posedge clk)
    begin
        if (smp_acc)
        begin
            inj_idx_reg <= swmm_pkg::IDX_W'(count_new - swmm_pkg::CNT_W'(1));
            vres_reg    <= (fill_next >= len_eff);
        end
    end

    // ------------------------------------------------------------------
    // cell chain: samples shift toward higher index, token toward cell 0
    // ------------------------------------------------------------------
    swmm_pkg::sample_t samp_arr [N];
    swmm_pkg::tok_t    tok_arr  [N];
    swmm_pkg::tok_t    tok_idle;

    assign tok_idle = '0;

    for (genvar k = 0; k < N; k++)
    begin : g_cell
        swmm_pkg::sample_t c_samp_in;
        swmm_pkg::tok_t    c_tok_in;
        logic              c_inject;

        if (k == 0)
        begin : g_head
            assign c_samp_in = smp.sample;
        end
        else
        begin : g_body
            assign c_samp_in = samp_arr[k-1];
        end

        if (k == N - 1)
        begin : g_tail
            assign c_tok_in = tok_idle;
        end
        else
        begin : g_link
            assign c_tok_in = tok_arr[k+1];
        end

        assign c_inject = start_reg & (inj_idx_reg == swmm_pkg::IDX_W'(k));

        swmm_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .shift_en (smp_acc),
            .samp_in  (c_samp_in),
            .samp     (samp_arr[k]),
            .inject   (c_inject),
            .tok_in   (c_tok_in),
            .tok_out  (tok_arr[k])
        );
    end

    // ------------------------------------------------------------------
    // control FSM and result buffering
    // ------------------------------------------------------------------
    swmm_pkg::state_t    state_reg, state_next;
    swmm_pkg::out_item_t out_reg, pend_reg, tok_res;
    logic                out_vld_reg, out_vld_next;
    logic                out_free;
    logic                done;
    logic                load_from_tok, load_from_pend, load_pend;

    assign done     = tok_arr[0].active;
    assign out_free = ~out_vld_reg | ~res_stall;

    assign tok_res.window_min = tok_arr[0].lo;
    assign tok_res.window_max = tok_arr[0].hi;
    assign tok_res.valid_res  = vres_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            swmm_pkg::ST_IDLE:
            begin
                if (smp_acc)
                begin
                    state_next = swmm_pkg::ST_SWEEP;
                end
            end
            swmm_pkg::ST_SWEEP:
            begin
                if (done)
                begin
                    state_next = out_free ? swmm_pkg::ST_IDLE : swmm_pkg::ST_PEND;
                end
            end
            swmm_pkg::ST_PEND:
            begin
                if (out_free)
                begin
                    state_next = swmm_pkg::ST_IDLE;
                end
            end
            default:
                state_next = swmm_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        smp_stall      = 1'b1;
        load_from_tok  = 1'b0;
        load_from_pend = 1'b0;
        load_pend      = 1'b0;
        unique case (state_reg)
            swmm_pkg::ST_IDLE:
                smp_stall = 1'b0;
            swmm_pkg::ST_SWEEP:
            begin
                load_from_tok = done & out_free;
                load_pend     = done & ~out_free;
            end
            swmm_pkg::ST_PEND:
                load_from_pend = out_free;
            default:
                smp_stall = 1'b1;
        endcase
    end

    always_comb
    begin
        if (load_from_tok | load_from_pend)
        begin
            out_vld_next = 1'b1;
        end
        else if (~res_stall)
        begin
            out_vld_next = 1'b0;
        end
        else
        begin
            out_vld_next = out_vld_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= swmm_pkg::ST_IDLE;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_from_tok)
        begin
            out_reg <= tok_res;
        end
        else if (load_from_pend)
        begin
            out_reg <= pend_reg;
        end
        if (load_pend)
        begin
            pend_reg <= tok_res;
        end
    end

    assign res_valid = out_vld_reg;
    assign res       = out_reg;

endmodule

// ----- test/testbench.sv -----
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    // Watchdog limit: cycles in a row with no item, result or register access.
    // Slowest legal gap is a full-window token walk behind a HOLD_CYCLES receiver hold.
    localparam int STALL_LIMIT = 4000;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES = 80;

    // ------------------------------------------------------------------
    // Clock, reset and DUT ports
    // ------------------------------------------------------------------
    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic smp_valid = 1'b0;
    logic smp_stall;
    swmm_pkg::in_item_t smp = '0;

    logic res_valid;
    logic res_stall = 1'b0;
    swmm_pkg::out_item_t res;

    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [swmm_pkg::PADDR_W-1:0] paddr = '0;
    logic [swmm_pkg::PDATA_W-1:0] pwdata = '0;
    logic [swmm_pkg::PDATA_W-1:0] prdata;
    logic pready;

    always #4 clk = ~clk;

    sliding_window_min_max dut (
        .clk(clk),
        .rst_n(rst_n),
        .smp_valid(smp_valid),
        .smp_stall(smp_stall),
        .smp(smp),
        .res_valid(res_valid),
        .res_stall(res_stall),
        .res(res),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    // ------------------------------------------------------------------
    // Shared testbench state
    // ------------------------------------------------------------------
    swmm_pkg::in_item_t pending_samples[$];    // items waiting to be offered
    swmm_pkg::out_item_t extremes_due[$];      // predicted min/max, oldest first

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_requests = 0;           // bumped by the sequencer to ask for a long hold

    int error_count = 0;
    int samples_sent = 0;
    int restarts_sent = 0;
    int results_checked = 0;
    int full_windows = 0;
    int settings_used = 0;

    // ------------------------------------------------------------------
    // Predictor: ring of recent samples plus series fill and write pointer
    // ------------------------------------------------------------------
    swmm_pkg::sample_t sample_ring[swmm_pkg::WINDOW_MAX];
    int series_fill = 0;
    int ring_slot = 0;
    logic [swmm_pkg::LEN_W-1:0] window_len_cfg = swmm_pkg::LEN_RESET;

    function automatic int span_of(logic [swmm_pkg::LEN_W-1:0] len);
        // zero acts as one, anything past the ring size is clipped
        if (len == 0)
            return 1;
        if (len > swmm_pkg::WINDOW_MAX)
            return swmm_pkg::WINDOW_MAX;
        return int'(len);
    endfunction

    function automatic swmm_pkg::out_item_t predict_extremes(swmm_pkg::in_item_t item);
        int span;
        int seen;
        int slot;
        swmm_pkg::sample_t lo;
        swmm_pkg::sample_t hi;
        swmm_pkg::out_item_t due;
        span = span_of(window_len_cfg);
        if (item.restart)
        begin
            series_fill = 0;
            ring_slot = 0;
        end
        sample_ring[ring_slot] = item.sample;
        slot = ring_slot;
        ring_slot = (ring_slot + 1) % swmm_pkg::WINDOW_MAX;
        if (series_fill < swmm_pkg::WINDOW_MAX)
            series_fill++;
        // only samples of the current series are looked at
        seen = (series_fill < span) ? series_fill : span;
        lo = item.sample;
        hi = item.sample;
        for (int k = 1; k < seen; k++)
        begin
            slot = (slot == 0) ? swmm_pkg::WINDOW_MAX - 1 : slot - 1;
            if (sample_ring[slot] < lo)
                lo = sample_ring[slot];
            if (sample_ring[slot] > hi)
                hi = sample_ring[slot];
        end
        due.window_min = lo;
        due.window_max = hi;
        due.valid_res = (series_fill >= span);
        return due;
    endfunction

    // ------------------------------------------------------------------
    // Sample driver: holds an offered item until it is taken
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            smp_valid <= 1'b0;
        end
        else
        begin
            if (smp_valid && !smp_stall)
            begin
                extremes_due.push_back(predict_extremes(smp));
                samples_sent++;
                if (smp.restart)
                    restarts_sent++;
            end
            // a new item may go out only once the old one is gone
            if (!smp_valid || !smp_stall)
            begin
                if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    smp <= pending_samples.pop_front();
                    smp_valid <= 1'b1;
                end
                else
                begin
                    smp_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor and stall generator
    // ------------------------------------------------------------------
    int hold_left = 0;
    int holds_served = 0;
    swmm_pkg::out_item_t oldest_due;

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            res_stall <= 1'b0;
        end
        else
        begin
            if (res_valid && !res_stall)
            begin
                if (extremes_due.size() == 0)
                begin
                    $display("%0t: result with nothing expected: min %0d max %0d valid %0b",
                             $time, $signed(res.window_min), $signed(res.window_max),
                             res.valid_res);
                    error_count++;
                end
                else
                begin
                    oldest_due = extremes_due.pop_front();
                    results_checked++;
                    if (oldest_due.valid_res)
                        full_windows++;
                    if (res.window_min !== oldest_due.window_min)
                    begin
                        $display("%0t: window_min expected %0d got %0d", $time,
                                 $signed(oldest_due.window_min), $signed(res.window_min));
                        error_count++;
                    end
                    if (res.window_max !== oldest_due.window_max)
                    begin
                        $display("%0t: window_max expected %0d got %0d", $time,
                                 $signed(oldest_due.window_max), $signed(res.window_max));
                        error_count++;
                    end
                    if (res.valid_res !== oldest_due.valid_res)
                    begin
                        $display("%0t: valid_res expected %0b got %0b", $time,
                                 oldest_due.valid_res, res.valid_res);
                        error_count++;
                    end
                end
            end
            // long hold lets the result buffers fill and back up the sample side
            if (hold_left > 0)
            begin
                hold_left--;
                res_stall <= 1'b1;
            end
            else if (holds_served != hold_requests)
            begin
                holds_served = hold_requests;
                hold_left = HOLD_CYCLES - 1;
                res_stall <= 1'b1;
            end
            else
            begin
                res_stall <= ($urandom_range(99) < recv_idle_pct);
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: counts cycles without any handshake
    // ------------------------------------------------------------------
    int quiet_cycles = 0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((smp_valid && !smp_stall) || (res_valid && !res_stall) || (psel && penable))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequencer helpers
    // ------------------------------------------------------------------
    task automatic queue_sample(swmm_pkg::sample_t value, logic restart);
        swmm_pkg::in_item_t item;
        item.sample = value;
        item.restart = restart;
        pending_samples.push_back(item);
    endtask

    // wait until the block holds nothing: no item queued, offered or in flight
    task automatic drain();
        while (pending_samples.size() != 0 || smp_valid || extremes_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // APB write of window_length, then read it back
    task automatic set_window_length(logic [swmm_pkg::LEN_W-1:0] len);
        logic [swmm_pkg::PDATA_W-1:0] readback;
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {swmm_pkg::REG_WINDOW_LENGTH, 2'b00};
        // junk in the unused upper bits must be ignored
        pwdata <= {(swmm_pkg::PDATA_W - swmm_pkg::LEN_W)'(
                       $urandom_range(2 ** (swmm_pkg::PDATA_W - swmm_pkg::LEN_W) - 1)),
                   len};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        window_len_cfg = len;
        settings_used++;
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        readback = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        if (readback !== swmm_pkg::PDATA_W'(len))
        begin
            $display("%0t: window_length readback expected %0d got %0d", $time, len, readback);
            error_count++;
        end
    endtask

    function automatic swmm_pkg::sample_t pick_sample();
        int kind;
        kind = $urandom_range(99);
        if (kind < 15)
        begin
            case ($urandom_range(3))
                0: return swmm_pkg::sample_t'(16'sh7FFF);
                1: return swmm_pkg::sample_t'(16'sh8000);
                2: return swmm_pkg::sample_t'(0);
                default: return swmm_pkg::sample_t'(-1);
            endcase
        end
        // narrow range gives plenty of ties between window entries
        if (kind < 45)
            return swmm_pkg::sample_t'($signed($urandom_range(16)) - 8);
        return swmm_pkg::sample_t'($urandom_range(16'hFFFF));
    endfunction

    // Random series: mostly a restart followed by a run longer than the window,
    // with the odd series that carries on across the boundary or restarts early.
    task automatic queue_series_mix(int count, logic [swmm_pkg::LEN_W-1:0] len);
        int run_left;
        int span;
        logic restart;
        run_left = 0;
        span = span_of(len);
        for (int i = 0; i < count; i++)
        begin
            if (run_left == 0)
            begin
                run_left = $urandom_range(2 * span + 12, 1);
                restart = ($urandom_range(9) != 0);
            end
            else
            begin
                restart = ($urandom_range(49) == 0);
            end
            run_left--;
            queue_sample(pick_sample(), restart);
        end
    endtask

    task automatic set_idling(int sender_pct, int receiver_pct);
        send_idle_pct = sender_pct;
        recv_idle_pct = receiver_pct;
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    int rand_len;

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at the reset window length of 4.
        set_idling(38, 70);
        settings_used++;
        queue_sample(swmm_pkg::sample_t'(16'sh7FFF), 1'b1);   // partial windows first
        queue_sample(swmm_pkg::sample_t'(16'sh8000), 1'b0);
        queue_sample(swmm_pkg::sample_t'(0), 1'b0);
        queue_sample(swmm_pkg::sample_t'(-1), 1'b0);           // window now full
        queue_sample(swmm_pkg::sample_t'(1), 1'b0);            // oldest extreme drops out
        queue_sample(swmm_pkg::sample_t'(16'sh7FFF), 1'b0);
        queue_sample(swmm_pkg::sample_t'(16'sh7FFF), 1'b0);
        queue_sample(swmm_pkg::sample_t'(16'sh8000), 1'b0);
        queue_sample(swmm_pkg::sample_t'(5), 1'b1);            // one-sample series
        queue_sample(swmm_pkg::sample_t'(-7), 1'b1);           // restart straight away
        queue_sample(swmm_pkg::sample_t'(100), 1'b0);
        queue_sample(swmm_pkg::sample_t'(-100), 1'b0);
        queue_sample(swmm_pkg::sample_t'(16'sh5555), 1'b0);
        queue_sample(swmm_pkg::sample_t'(16'shAAAA), 1'b0);
        queue_sample(swmm_pkg::sample_t'(3), 1'b1);            // restart mid-window
        queue_sample(swmm_pkg::sample_t'(3), 1'b0);
        queue_sample(swmm_pkg::sample_t'(3), 1'b0);
        queue_sample(swmm_pkg::sample_t'(3), 1'b0);
        queue_sample(swmm_pkg::sample_t'(2), 1'b0);
        queue_sample(swmm_pkg::sample_t'(16'sh8000), 1'b0);
        drain();

        // Phases without a restart at the start exercise a length change
        // in the middle of a running series.
        set_window_length(7'd1);
        queue_series_mix(200, 7'd1);
        drain();

        set_window_length(7'd64);
        queue_series_mix(60, 7'd64);
        drain();

        set_window_length(7'd0);                     // behaves as a length of one
        queue_series_mix(150, 7'd0);
        drain();

        // Sender now idles more than the receiver.
        set_idling(70, 38);
        set_window_length(7'd127);                   // clipped to the ring size
        queue_series_mix(50, 7'd127);
        drain();

        set_window_length(7'd65);
        queue_series_mix(40, 7'd65);
        drain();

        // Pause the sender part way until every result is back.
        set_window_length(7'd3);
        queue_series_mix(100, 7'd3);
        drain();
        queue_series_mix(100, 7'd3);
        drain();

        // No idling on either side; one long receiver hold backs up the block.
        set_idling(0, 0);
        rand_len = $urandom_range(16, 2);
        set_window_length(swmm_pkg::LEN_W'(rand_len));
        queue_series_mix(250, swmm_pkg::LEN_W'(rand_len));
        hold_requests++;
        drain();

        rand_len = $urandom_range(64, 1);
        set_window_length(swmm_pkg::LEN_W'(rand_len));
        queue_series_mix(80, swmm_pkg::LEN_W'(rand_len));
        drain();

        set_window_length(7'd8);
        queue_series_mix(150, 7'd8);
        drain();

        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d samples with %0d restarts over %0d window settings",
                 samples_sent, restarts_sent, settings_used);
        $display("including 0, 1, 64, 65 and 127; %0d results checked, %0d with a full window",
                 results_checked, full_windows);
        if (error_count == 0 && extremes_due.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
